FILE: design/hfbe_pkg.sv
// shared types, codes and constants for the hdlc frame bit encoder
`timescale 1ns / 1ps

package hfbe_pkg;

    // input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    // line constants
    localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
    localparam logic [7:0]  FILL_BYTE     = 8'hFF;
    localparam logic [9:0]  PREAMBLE_BITS = 10'h0FF;
    localparam logic [3:0]  PREAMBLE_CNT  = 4'd8;
    localparam int unsigned PREAMBLE_STEPS = 4;
    localparam logic [2:0]  STUFF_LIMIT   = 3'd5;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    // configuration
    localparam logic [4:0] LEAD_FLAGS_RESET = 5'd6;
    localparam logic [4:0] LEAD_FLAGS_MIN   = 5'd1;
    localparam logic [4:0] LEAD_FLAGS_MAX   = 5'd16;

    // step counter covers preamble plus the longest flag run
    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] END_LAST_STEP = 5'd4;

    // default depth of the command queue
    localparam int unsigned HFBE_QUEUE_DEPTH = 2;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // one queued command
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data_byte;
        logic [STEP_W-1:0] last_step;
    } cmd_t;

    // result of encoding one byte
    typedef struct packed {
        logic [9:0] bits;
        logic [3:0] count;
        logic [2:0] ones;
        logic       level;
    } enc_t;

endpackage

FILE: design/hfbe_front.sv
// front end: config register, request acceptance and classification
`timescale 1ns / 1ps

module hfbe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [7:0]          data_byte,
    input  logic                q_full,
    output logic                q_push,
    output hfbe_pkg::cmd_t      q_cmd
);
    import hfbe_pkg::*;

    logic [4:0]        lead_flags_reg;
    logic [4:0]        flags_clamped;
    logic              action_ok;
    logic              in_take;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_flags_reg <= LEAD_FLAGS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lead_flags_reg <= cfg_data;
        end
    end

    // flag count limited to the legal range
    always_comb
    begin
        if (lead_flags_reg < LEAD_FLAGS_MIN)
            flags_clamped = LEAD_FLAGS_MIN;
        else if (lead_flags_reg > LEAD_FLAGS_MAX)
            flags_clamped = LEAD_FLAGS_MAX;
        else
            flags_clamped = lead_flags_reg;
    end

    // classify the request into a command
    always_comb
    begin
        action_ok         = 1'b1;
        q_cmd.kind        = KIND_DATA;
        q_cmd.data_byte   = data_byte;
        q_cmd.last_step   = '0;
        case (action)
            ACT_START:
            begin
                q_cmd.kind      = KIND_START;
                q_cmd.last_step = STEP_W'(PREAMBLE_STEPS - 1) + flags_clamped;
            end
            ACT_DATA:
            begin
                q_cmd.kind      = KIND_DATA;
                q_cmd.last_step = '0;
            end
            ACT_END:
            begin
                q_cmd.kind      = KIND_END;
                q_cmd.last_step = END_LAST_STEP;
            end
            default:
            begin
                // unknown action is taken and dropped
                action_ok = 1'b0;
            end
        endcase
    end

    // accept when the queue has room
    assign in_stall = q_full;
    assign in_take  = in_valid && !in_stall;
    assign q_push   = in_take && action_ok;

endmodule

FILE: design/hfbe_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module hfbe_queue #(
    parameter int unsigned DEPTH = hfbe_pkg::HFBE_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hfbe_pkg::cmd_t      push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output hfbe_pkg::cmd_t      head_cmd
);
    import hfbe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t               entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: design/hfbe_back.sv
// back end: crc, bit stuffing, nrzi coding and the output register
`timescale 1ns / 1ps

module hfbe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  hfbe_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          line_bits,
    output logic [3:0]          bit_count,
    output logic                last
);
    import hfbe_pkg::*;

    // one byte, lsb first, with optional zero stuffing and nrzi
    function automatic enc_t encode_byte(input logic [7:0] b, input logic stuff,
                                         input logic [2:0] ones_in, input logic lvl_in);
        enc_t       r;
        logic [2:0] ones;
        logic       lvl;
        logic [3:0] cnt;
        logic [9:0] bits;
        ones = ones_in;
        lvl  = lvl_in;
        cnt  = '0;
        bits = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                ones = ones + 3'd1;
                if (ones >= STUFF_LIMIT)
                begin
                    ones = '0;
                    if (stuff)
                    begin
                        bits[cnt] = lvl;
                        cnt       = cnt + 4'd1;
                        lvl       = ~lvl;
                    end
                end
            end
            else
            begin
                ones = '0;
                lvl  = ~lvl;
            end
            bits[cnt] = lvl;
            cnt       = cnt + 4'd1;
        end
        r.bits  = bits;
        r.count = cnt;
        r.ones  = ones;
        r.level = lvl;
        return r;
    endfunction

    // reflected crc-16/x.25 over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [2:0]        ones_reg;
    logic              level_reg;
    logic [15:0]       fcs_reg;
    logic              out_valid_reg;
    logic [9:0]        line_bits_reg;
    logic [3:0]        bit_count_reg;
    logic              last_reg;

    logic [2:0]        ones_next;
    logic              level_next;
    logic [15:0]       fcs_next;
    logic [9:0]        bits_sel;
    logic [3:0]        count_sel;
    logic [7:0]        enc_byte;
    logic              enc_stuff;
    logic              use_enc;
    logic [15:0]       fcs_inv;
    logic              fire;
    logic              is_last;
    enc_t              enc;

    assign fire    = head_valid && (!out_valid_reg || !out_stall);
    assign is_last = (step_reg == head_cmd.last_step);
    assign pop     = fire && is_last;
    assign fcs_inv = ~fcs_reg;

    // pick the byte and stuffing mode for this step
    always_comb
    begin
        enc_byte  = FLAG_BYTE;
        enc_stuff = 1'b0;
        use_enc   = 1'b1;
        case (head_cmd.kind)
            KIND_START:
            begin
                use_enc = (step_reg >= STEP_W'(PREAMBLE_STEPS));
            end
            KIND_DATA:
            begin
                enc_byte  = head_cmd.data_byte;
                enc_stuff = 1'b1;
            end
            KIND_END:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        enc_byte  = fcs_inv[7:0];
                        enc_stuff = 1'b1;
                    end
                    5'd1:
                    begin
                        enc_byte  = fcs_inv[15:8];
                        enc_stuff = 1'b1;
                    end
                    5'd2:    enc_byte = FLAG_BYTE;
                    default: enc_byte = FILL_BYTE;
                endcase
            end
            default:
            begin
                use_enc = 1'b0;
            end
        endcase
    end

    assign enc = encode_byte(enc_byte, enc_stuff, ones_reg, level_reg);

    // next line state and result word
    always_comb
    begin
        ones_next  = ones_reg;
        level_next = level_reg;
        fcs_next   = fcs_reg;
        bits_sel   = PREAMBLE_BITS;
        count_sel  = PREAMBLE_CNT;
        if (use_enc)
        begin
            bits_sel   = enc.bits;
            count_sel  = enc.count;
            ones_next  = enc.ones;
            level_next = enc.level;
        end
        if (head_cmd.kind == KIND_DATA)
            fcs_next = crc_byte(fcs_reg, head_cmd.data_byte);
        // frame start clears the line state
        if (head_cmd.kind == KIND_START && step_reg == '0)
        begin
            ones_next  = '0;
            level_next = 1'b1;
            fcs_next   = CRC_INIT;
        end
    end

    // control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            ones_reg      <= '0;
            level_reg     <= 1'b1;
            fcs_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                step_reg      <= is_last ? '0 : step_reg + 1'b1;
                ones_reg      <= ones_next;
                level_reg     <= level_next;
                fcs_reg       <= fcs_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            line_bits_reg <= bits_sel;
            bit_count_reg <= count_sel;
            last_reg      <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_bits = line_bits_reg;
    assign bit_count = bit_count_reg;
    assign last      = last_reg;

endmodule

FILE: design/hdlc_frame_bit_encoder.sv
// top level of the hdlc frame bit encoder
`timescale 1ns / 1ps

// HDLC line encoder for AX.25 frames: preamble, flags, stuffed NRZI data, FCS.
// Input channel (in_valid/in_stall): action 0 starts a frame, 1 sends data_byte,
// 2 ends the frame; action 3 is taken and dropped. Output channel
// (out_valid/out_stall): line_bits holds bit_count (8..10) line levels, first
// in bit 0; last marks the final result of a request.
// Results per request: start gives 4 preamble words plus lead_flags (clamped to 1..16) flags,
// data gives 1, end gives 5 (two FCS bytes, a flag, two fill bytes).
// The config channel (cfg_valid/cfg_ready/cfg_data) writes lead_flags; it is
// always ready. The user writes it only while no frame work is pending; the
// block does not enforce this. Results pass the queue and output register.
// The back end gives one result per cycle while out_stall is low, so data
// bytes then go at one per cycle; a start holds it for its preamble and flag
// words, an end for its five words. The command queue (QUEUE_DEPTH entries)
// lets requests keep coming in while the back end works through a longer
// request. Reset clears the queue and output valid, sets lead_flags to 6,
// the line level to one and the FCS to all ones. While out_stall is high the
// result holds, the back end waits, and in_stall rises once the queue is full.
module hdlc_frame_bit_encoder #(
    parameter int unsigned QUEUE_DEPTH = hfbe_pkg::HFBE_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  line_bits,
    output logic [3:0]  bit_count,
    output logic        last
);
    import hfbe_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic head_valid;
    cmd_t head_cmd;

    // request acceptance and classification
    hfbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // command queue
    hfbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // line encoding
    hfbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_bits  (line_bits),
        .bit_count  (bit_count),
        .last       (last)
    );

`ifndef SYNTH
    // result width stays within one byte plus two stuffed bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bit_count == 4'd8 || bit_count == 4'd9 || bit_count == 4'd10))
        else $error("bit_count out of range");

    // bits above the count are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bit_count == 4'd8) |-> (line_bits[9:8] == 2'b00))
        else $error("stray bits above an 8 bit result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bit_count == 4'd9) |-> (line_bits[9] == 1'b0))
        else $error("stray bit above a 9 bit result");

    // a new result is only loaded once the previous one was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(line_bits) && $stable(last)))
        else $error("stalled result changed");
`endif

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the hdlc frame bit encoder
`timescale 1ns / 1ps

module testbench;
    import hfbe_pkg::*;

    // action code the block drops
    localparam logic [1:0] ACT_NONE = 2'd3;
    // extra cycles after the last result before a register write or the end
    localparam int FLUSH_CYCLES = 8;
    // length of the forced output hold-off
    localparam int HOLD_OFF_CYCLES = 150;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] dbyte;
    } frame_req_t;

    typedef struct packed {
        logic [9:0] bits;
        logic [3:0] count;
        logic       last;
    } line_word_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // block ports
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] action = '0;
    logic [7:0] data_byte = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [9:0] line_bits;
    logic [3:0] bit_count;
    logic       last;

    // stimulus and expected line words
    frame_req_t frame_reqs[$];
    line_word_t expected_words[$];
    int         live_count = 0;
    int         mismatches = 0;
    bit         req_taken = 1'b0;
    idle_mode_t idle_mode = IDLE_NONE;
    bit         pressure_go = 1'b0;
    logic       hold_off = 1'b0;
    frame_req_t drive_req;
    frame_req_t seen_req;

    // encoder state as predicted
    logic [4:0]  lead_cfg = LEAD_FLAGS_RESET;
    logic [2:0]  enc_ones = '0;
    logic        enc_level = 1'b1;
    logic [15:0] enc_fcs = CRC_INIT;

    hdlc_frame_bit_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .line_bits (line_bits),
        .bit_count (bit_count),
        .last      (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit send_gap();
        case (idle_mode)
            IDLE_SEND: return roll(47);
            IDLE_BOTH: return roll(11);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall();
        case (idle_mode)
            IDLE_RECV: return roll(47);
            IDLE_BOTH: return roll(11);
            default:   return 1'b0;
        endcase
    endfunction

    // reflected crc-16/x.25 over one byte
    function automatic void fold_crc(input logic [7:0] b);
        logic [15:0] c;
        int i;
        c = enc_fcs ^ {8'h00, b};
        for (i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        enc_fcs = c;
    endfunction

    // one byte lsb first, optional zero stuffing, nrzi
    function automatic line_word_t encode_byte(input logic [7:0] b, input bit stuff);
        line_word_t w;
        logic [9:0] bits;
        int ones;
        int n;
        int i;
        logic lvl;
        bits = '0;
        ones = enc_ones;
        lvl = enc_level;
        n = 0;
        for (i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                ones++;
                // run of five ones: counter clears, zero inserted only when stuffing
                if (ones >= STUFF_LIMIT)
                begin
                    ones = 0;
                    if (stuff)
                    begin
                        bits[n] = lvl;
                        n++;
                        lvl = ~lvl;
                    end
                end
            end
            else
            begin
                ones = 0;
                lvl = ~lvl;
            end
            bits[n] = lvl;
            n++;
        end
        enc_ones = ones[2:0];
        enc_level = lvl;
        w.bits = bits;
        w.count = n[3:0];
        w.last = 1'b0;
        return w;
    endfunction

    function automatic void push_word(input line_word_t w, input bit is_last);
        w.last = is_last;
        expected_words.push_back(w);
    endfunction

    // expected line words for one accepted request
    function automatic void encode_request(input frame_req_t r);
        int flags;
        int i;
        logic [15:0] fcs_out;
        line_word_t pre;
        case (r.act)
            ACT_START:
            begin
                // flag count clamped into 1..16
                flags = lead_cfg;
                if (flags < LEAD_FLAGS_MIN)
                    flags = LEAD_FLAGS_MIN;
                if (flags > LEAD_FLAGS_MAX)
                    flags = LEAD_FLAGS_MAX;
                enc_ones = '0;
                enc_level = 1'b1;
                enc_fcs = CRC_INIT;
                pre.bits = PREAMBLE_BITS;
                pre.count = PREAMBLE_CNT;
                pre.last = 1'b0;
                for (i = 0; i < PREAMBLE_STEPS; i++)
                    push_word(pre, 1'b0);
                for (i = 0; i < flags; i++)
                    push_word(encode_byte(FLAG_BYTE, 1'b0), i == flags - 1);
            end
            ACT_DATA:
            begin
                fold_crc(r.dbyte);
                push_word(encode_byte(r.dbyte, 1'b1), 1'b1);
            end
            ACT_END:
            begin
                fcs_out = ~enc_fcs;
                push_word(encode_byte(fcs_out[7:0], 1'b1), 1'b0);
                push_word(encode_byte(fcs_out[15:8], 1'b1), 1'b0);
                push_word(encode_byte(FLAG_BYTE, 1'b0), 1'b0);
                push_word(encode_byte(FILL_BYTE, 1'b0), 1'b0);
                push_word(encode_byte(FILL_BYTE, 1'b0), 1'b1);
            end
            default: ;
        endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function automatic void check_word();
        line_word_t want;
        if (expected_words.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected result: line_bits %h bit_count %0d last %0b",
                         line_bits, bit_count, last);
            mismatches++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (line_bits !== want.bits || bit_count !== want.count || last !== want.last)
            begin
                if (mismatches < 10)
                    $display({"mismatch: expected line_bits %h bit_count %0d last %0b,",
                              " got line_bits %h bit_count %0d last %0b"},
                             want.bits, want.count, want.last, line_bits, bit_count, last);
                mismatches++;
            end
        end
    endfunction

    // monitor: register writes, accepted requests, accepted results
    always @(posedge clk)
    begin
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            req_taken = in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
                lead_cfg = cfg_data;
            if (req_taken)
            begin
                seen_req.act = action;
                seen_req.dbyte = data_byte;
                encode_request(seen_req);
            end
            if (out_valid && !out_stall)
                check_word();
        end
    end

    // driver: holds a stalled request, otherwise offers the next one or a gap
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (frame_reqs.size() != 0 && !send_gap())
            begin
                drive_req = frame_reqs.pop_front();
                in_valid <= 1'b1;
                action <= drive_req.act;
                data_byte <= drive_req.dbyte;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || recv_stall();
    end

    // one long hold-off on the output so the input side fills up
    initial
    begin
        wait (pressure_go);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    function automatic void queue_req(input logic [1:0] act, input logic [7:0] b);
        frame_req_t r;
        r.act = act;
        r.dbyte = b;
        frame_reqs.push_back(r);
        if (act != ACT_NONE)
            live_count++;
    endfunction

    // payload bytes biased toward long runs of ones
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'($urandom | $urandom);
            1:       return FILL_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // a frame with random payload, sometimes missing its start or end
    function automatic void queue_frame();
        int n;
        int i;
        bit keep_start;
        bit keep_end;
        keep_start = $urandom_range(99) >= 8;
        keep_end = $urandom_range(99) >= 8;
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        if (keep_start)
            queue_req(ACT_START, 8'($urandom_range(255)));
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                queue_req(ACT_NONE, 8'($urandom_range(255)));
            queue_req(ACT_DATA, pick_byte());
        end
        if (keep_end)
            queue_req(ACT_END, 8'($urandom_range(255)));
    endfunction

    function automatic void add_random(input int target);
        int first;
        first = live_count;
        while (live_count - first < target)
        begin
            if ($urandom_range(99) < 85)
                queue_frame();
            else
                queue_req(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endfunction

    // wait until every request is taken and every result has arrived
    task automatic wait_idle();
        while (frame_reqs.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_lead_flags(input logic [4:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [4:0] flags_val, input idle_mode_t mode,
                             input int n_items, input bit squeeze);
        write_lead_flags(flags_val);
        idle_mode = mode;
        add_random(n_items);
        if (squeeze)
            pressure_go = 1'b1;
        wait_idle();
    endtask

    // main sequence
    initial
    begin
        // directed: data and end before any start, every action, edge bytes
        queue_req(ACT_DATA, 8'hFF);
        queue_req(ACT_DATA, 8'hFF);
        queue_req(ACT_END, 8'h00);
        queue_req(ACT_NONE, 8'hA5);
        queue_req(ACT_START, 8'hFF);
        queue_req(ACT_DATA, 8'h00);
        queue_req(ACT_DATA, 8'hFF);
        queue_req(ACT_DATA, 8'hFF);
        queue_req(ACT_DATA, 8'h7E);
        queue_req(ACT_DATA, 8'h01);
        queue_req(ACT_DATA, 8'h80);
        queue_req(ACT_DATA, 8'hAA);
        queue_req(ACT_DATA, 8'h55);
        queue_req(ACT_DATA, 8'hF8);
        queue_req(ACT_DATA, 8'h1F);
        queue_req(ACT_END, 8'hFF);
        // after end the state carries on until the next start
        queue_req(ACT_DATA, 8'h3C);
        queue_req(ACT_END, 8'h00);
        // empty frame
        queue_req(ACT_START, 8'h00);
        queue_req(ACT_END, 8'h00);
        queue_req(ACT_NONE, 8'h5A);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // register extremes, out-of-range values and random settings
        run_phase(5'd0, IDLE_NONE, 45, 1'b1);
        run_phase(5'd16, IDLE_SEND, 45, 1'b0);
        run_phase(5'd31, IDLE_RECV, 45, 1'b0);
        run_phase(5'd1, IDLE_BOTH, 45, 1'b0);
        run_phase(5'd17, IDLE_NONE, 40, 1'b0);
        run_phase(5'($urandom_range(31)), IDLE_SEND, 40, 1'b0);
        run_phase(5'($urandom_range(31)), IDLE_RECV, 40, 1'b0);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
